// File: rtl/osrb_pkg.sv
// ============================================================================
// osrb_pkg: shared types and constants of the sequence reorder buffer
// Beat formats, status codes and the controller to datapath command and
// status groups.
// ============================================================================
package osrb_pkg;

    // Default sizing, handed down from the top level
    localparam int DEF_SLOTS    = 32;
    localparam int DEF_CHANNELS = 4;

    // Fixed field widths
    localparam int CHAN_W = 2;
    localparam int SEQ_W  = 32;
    localparam int TAG_W  = 16;
    localparam int PEND_W = 6;

    // Wrap-aware stale threshold
    localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_DELIVERED     = 3'd0,
        ST_DRAINED       = 3'd1,
        ST_BUFFERED      = 3'd2,
        ST_DUPLICATE     = 3'd3,
        ST_STALE         = 3'd4,
        ST_OUT_OF_WINDOW = 3'd5
    } status_t;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [SEQ_W-1:0]  sequence_req;
        logic              reliable;
        logic [TAG_W-1:0]  payload_tag;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  released_tag;
        logic [SEQ_W-1:0]  released_seq;
        logic [PEND_W-1:0] pending_count;
        logic              last;
    } result_t;

    // Controller commands
    typedef struct packed {
        logic capture;   // accept the input beat
        logic classify;  // evaluate against the expected number
        logic buffer;    // store into the slot
        logic drain;     // release and check the next slot
    } cmd_t;

    // Datapath status
    typedef struct packed {
        logic in_order;
        logic in_window;
        logic drain_hit;
    } sts_t;

endpackage

// File: rtl/ordered_seq_reorder_buffer.sv
// ============================================================================
// ordered_seq_reorder_buffer: per-channel sequence-number reorder buffer
// Releases packet descriptors in sequence order, buffering early arrivals.
// ============================================================================
// A beat is captured when start is taken in idle, then classified; a stale or
// out-of-window result is registered from the classify step, a buffered one
// from the buffer step, in-order releases from the drain steps, one per step,
// one slot RAM read per drain step; busy holds off the next beat until done.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
// Reset clears expected numbers, pending counts and slot valid bits at once.
module ordered_seq_reorder_buffer #(
    parameter int SLOTS    = osrb_pkg::DEF_SLOTS,
    parameter int CHANNELS = osrb_pkg::DEF_CHANNELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  osrb_pkg::item_t   item,
    output osrb_pkg::result_t result,
    output logic              result_valid
);

    import osrb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    osrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    osrb_datapath #(
        .SLOTS    (SLOTS),
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// File: rtl/osrb_ram.sv
// ============================================================================
// osrb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ============================================================================
module osrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/osrb_ctrl.sv
// ============================================================================
// osrb_ctrl: sequencing state machine of the reorder buffer
// Steps each accepted beat through classify, buffer or drain.
// ============================================================================
module osrb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  osrb_pkg::sts_t sts,
    output osrb_pkg::cmd_t cmd,
    output logic          busy
);

    import osrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLASSIFY,
        S_BUFFER,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (sts.in_order)
                begin
                    state_next = S_DRAIN;
                end
                else if (sts.in_window)
                begin
                    state_next = S_BUFFER;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BUFFER:
            begin
                state_next = S_IDLE;
            end
            S_DRAIN:
            begin
                if (!sts.drain_hit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands decoded from state
    assign cmd.capture  = (state_reg == S_IDLE) && start;
    assign cmd.classify = (state_reg == S_CLASSIFY);
    assign cmd.buffer   = (state_reg == S_BUFFER);
    assign cmd.drain    = (state_reg == S_DRAIN);
    assign busy         = (state_reg != S_IDLE);

endmodule

// File: rtl/osrb_datapath.sv
// ============================================================================
// osrb_datapath: per-channel expected numbers, slot store and result beats
// Holds the channel state, valid bits and slot RAM, and forms every result.
// ============================================================================
module osrb_datapath #(
    parameter int SLOTS    = osrb_pkg::DEF_SLOTS,
    parameter int CHANNELS = osrb_pkg::DEF_CHANNELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  osrb_pkg::cmd_t    cmd,
    input  osrb_pkg::item_t   item,
    output osrb_pkg::sts_t    sts,
    output osrb_pkg::result_t result,
    output logic              result_valid
);

    import osrb_pkg::*;

    // only four channels are reachable through a two-bit channel field
    localparam int CH_USED = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int CH_W    = (CH_USED > 1) ? $clog2(CH_USED) : 1;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int DEPTH   = CH_USED * SLOTS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // slot shift when a window crosses the 2^32 wrap of the sequence number
    localparam int WRAP_MOD = int'((64'd1 << SEQ_W) % SLOTS);
    localparam int WRAP_ADJ = (SLOTS - WRAP_MOD) % SLOTS;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
    } slot_entry_t;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
    } held_t;

    // expected number modulo SLOTS after one increment
    function automatic logic [SLOT_W-1:0] mod_inc(input logic [SLOT_W-1:0] m,
                                                  input logic [SEQ_W-1:0] v);
        logic [SLOT_W-1:0] r;
        if (v == {SEQ_W{1'b1}})
        begin
            r = '0;
        end
        else if (m == SLOT_W'(SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = m + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] c,
                                                    input logic [SLOT_W-1:0] s);
        return ADDR_W'(c) * ADDR_W'(SLOTS) + ADDR_W'(s);
    endfunction

    // channel state
    logic [SEQ_W-1:0]  ne_reg        [CH_USED];
    logic [SEQ_W-1:0]  ne_next       [CH_USED];
    logic [SLOT_W-1:0] emod_reg      [CH_USED];
    logic [SLOT_W-1:0] emod_next     [CH_USED];
    logic [PEND_W-1:0] pend_reg      [CH_USED];
    logic [PEND_W-1:0] pend_next     [CH_USED];
    logic [SEQ_W-1:0]  stale_reg     [CH_USED];
    logic [SEQ_W-1:0]  stale_next    [CH_USED];
    logic [SEQ_W-1:0]  dup_reg       [CH_USED];
    logic [SEQ_W-1:0]  dup_next      [CH_USED];
    logic [SEQ_W-1:0]  deliv_reg     [CH_USED];
    logic [SEQ_W-1:0]  deliv_next    [CH_USED];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    // captured beat and working payload
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              rel_reg, rel_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    held_t             held_reg, held_next;
    result_t           res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    // slot RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    slot_entry_t       ram_wdata;
    slot_entry_t       ram_rdata;

    // classify terms
    logic [SEQ_W-1:0]  exp_raw, exp_fix, delta;
    logic [SLOT_W-1:0] emod_fix, buf_slot, adv_slot;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W:0]   wrap_sum;
    logic              in_order, is_stale, in_window;
    logic [ADDR_W-1:0] cur_addr, buf_addr;
    logic              buf_hit, drain_hit;

    osrb_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // expected number after the zero-as-one fixup, and window position
    always_comb
    begin
        exp_raw   = ne_reg[ch_reg];
        exp_fix   = (exp_raw == '0) ? SEQ_W'(1) : exp_raw;
        emod_fix  = (exp_raw == '0) ? SLOT_W'(1) : emod_reg[ch_reg];
        delta     = seq_reg - exp_fix;
        in_order  = (delta == '0);
        is_stale  = (delta > HALF_RANGE);
        in_window = !in_order && (delta < SEQ_W'(SLOTS));
        slot_sum  = {1'b0, emod_fix} + {1'b0, delta[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W + 1)'(SLOTS))
        begin
            buf_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(SLOTS));
        end
        else
        begin
            buf_slot = SLOT_W'(slot_sum);
        end
        // sequence number wrapped past zero inside the window
        wrap_sum  = {1'b0, buf_slot} + (SLOT_W + 1)'(WRAP_ADJ);
        if (seq_reg < exp_fix)
        begin
            if (wrap_sum >= (SLOT_W + 1)'(SLOTS))
            begin
                buf_slot = SLOT_W'(wrap_sum - (SLOT_W + 1)'(SLOTS));
            end
            else
            begin
                buf_slot = SLOT_W'(wrap_sum);
            end
        end
        adv_slot  = mod_inc(emod_reg[ch_reg], ne_reg[ch_reg]);
        cur_addr  = slot_addr(ch_reg, emod_reg[ch_reg]);
        buf_addr  = slot_addr(ch_reg, slot_reg);
        buf_hit   = valid_reg[buf_addr] && (ram_rdata.seq == seq_reg);
        drain_hit = valid_reg[cur_addr] && (ram_rdata.seq == ne_reg[ch_reg]);
    end

    assign sts.in_order  = in_order;
    assign sts.in_window = in_window;
    assign sts.drain_hit = drain_hit;

    // next-state logic for all steps
    always_comb
    begin
        ne_next        = ne_reg;
        emod_next      = emod_reg;
        pend_next      = pend_reg;
        stale_next     = stale_reg;
        dup_next       = dup_reg;
        deliv_next     = deliv_reg;
        valid_next     = valid_reg;
        ch_next        = ch_reg;
        seq_next       = seq_reg;
        rel_next       = rel_reg;
        tag_next       = tag_reg;
        slot_next      = slot_reg;
        held_next      = held_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = buf_addr;
        ram_wdata      = '{seq: seq_reg, tag: tag_reg};
        ram_raddr      = cur_addr;

        // capture the beat; unused channel codes fold onto channel 0
        if (cmd.capture)
        begin
            if (int'(item.channel) >= CHANNELS)
            begin
                ch_next = '0;
            end
            else
            begin
                ch_next = CH_W'(item.channel);
            end
            seq_next = item.sequence_req;
            rel_next = item.reliable;
            tag_next = item.payload_tag;
        end

        // classify against the expected number
        if (cmd.classify)
        begin
            ne_next[ch_reg]   = exp_fix;
            emod_next[ch_reg] = emod_fix;
            if (in_order)
            begin
                ne_next[ch_reg]   = exp_fix + 1'b1;
                emod_next[ch_reg] = mod_inc(emod_fix, exp_fix);
                ram_raddr         = slot_addr(ch_reg, mod_inc(emod_fix, exp_fix));
                held_next         = '{status: ST_DELIVERED, tag: tag_reg, seq: seq_reg};
            end
            else if (in_window)
            begin
                slot_next = buf_slot;
                ram_raddr = slot_addr(ch_reg, buf_slot);
            end
            else
            begin
                stale_next[ch_reg] = stale_reg[ch_reg] + 1'b1;
                if (is_stale && rel_reg)
                begin
                    dup_next[ch_reg] = dup_reg[ch_reg] + 1'b1;
                end
                res_valid_next = 1'b1;
                res_next = '{status:        is_stale ? ST_STALE : ST_OUT_OF_WINDOW,
                             released_tag:  '0,
                             released_seq:  seq_reg,
                             pending_count: pend_reg[ch_reg],
                             last:          1'b1};
            end
        end

        // store into the slot, counting a rewrite of the same sequence
        if (cmd.buffer)
        begin
            ram_we = 1'b1;
            valid_next[buf_addr] = 1'b1;
            if (buf_hit)
            begin
                dup_next[ch_reg] = dup_reg[ch_reg] + 1'b1;
            end
            else if (!valid_reg[buf_addr])
            begin
                pend_next[ch_reg] = pend_reg[ch_reg] + 1'b1;
            end
            res_valid_next = 1'b1;
            res_next = '{status:        buf_hit ? ST_DUPLICATE : ST_BUFFERED,
                         released_tag:  '0,
                         released_seq:  seq_reg,
                         pending_count: pend_next[ch_reg],
                         last:          1'b1};
        end

        // release the held beat; pull the next slot if it continues the run
        if (cmd.drain)
        begin
            res_valid_next = 1'b1;
            res_next = '{status:        held_reg.status,
                         released_tag:  held_reg.tag,
                         released_seq:  held_reg.seq,
                         pending_count: pend_reg[ch_reg],
                         last:          !drain_hit};
            if (drain_hit)
            begin
                valid_next[cur_addr] = 1'b0;
                if (pend_reg[ch_reg] != '0)
                begin
                    pend_next[ch_reg] = pend_reg[ch_reg] - 1'b1;
                end
                ne_next[ch_reg]    = ne_reg[ch_reg] + 1'b1;
                emod_next[ch_reg]  = adv_slot;
                deliv_next[ch_reg] = deliv_reg[ch_reg] + 1'b1;
                ram_raddr          = slot_addr(ch_reg, adv_slot);
                held_next = '{status: ST_DRAINED, tag: ram_rdata.tag,
                              seq: ne_reg[ch_reg]};
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_USED; i++)
            begin
                ne_reg[i]    <= '0;
                emod_reg[i]  <= '0;
                pend_reg[i]  <= '0;
                stale_reg[i] <= '0;
                dup_reg[i]   <= '0;
                deliv_reg[i] <= '0;
            end
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ne_reg        <= ne_next;
            emod_reg      <= emod_next;
            pend_reg      <= pend_next;
            stale_reg     <= stale_next;
            dup_reg       <= dup_next;
            deliv_reg     <= deliv_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        seq_reg  <= seq_next;
        rel_reg  <= rel_next;
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
        held_reg <= held_next;
        res_reg  <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

`ifndef ASSERT_OFF
    // pending never exceeds the slot count of a channel
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.classify |-> pend_reg[ch_reg] <= PEND_W'(SLOTS))
        else $error("pending count above slot count");

    // a drained slot is freed
    a_drain_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain && drain_hit) |=> !valid_reg[$past(cur_addr)])
        else $error("drained slot still valid");

    // a buffered beat leaves its slot valid
    a_buffer_sets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.buffer |=> valid_reg[$past(buf_addr)])
        else $error("buffered slot not valid");

    // a result beat only follows a working step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(cmd.classify || cmd.buffer || cmd.drain))
        else $error("result strobe without a working step");
`endif

endmodule

// File: tb/tb_top.sv
// ============================================================================
// tb_top: testbench of the per-channel sequence reorder buffer
// A queue-fed driver offers packet beats with random gaps. Each accepted beat
// runs through an in-bench reorder predictor, and a monitor compares every
// strobed result field by field against the oldest predicted outcome.
// ============================================================================
module tb_top;
    import osrb_pkg::*;

    localparam int SLOTS      = DEF_SLOTS;
    localparam int CHANNELS   = DEF_CHANNELS;
    localparam int STALL_MAX  = 1000;
    localparam int PHASE_BEATS = 62;
    localparam int PRINT_MAX  = 60;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    result_t result;
    logic    result_valid;

    ordered_seq_reorder_buffer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

    // Packet beats waiting to be offered, and predicted outcomes in order
    item_t   packet_q[$];
    result_t outcome_q[$];
    int      queued    = 0;
    int      accepted  = 0;
    int      errors    = 0;
    int      idle_pct  = 36;
    int      quiet_cycles = 0;

    // Predictor state, one set per channel
    logic [SEQ_W-1:0]  next_seq   [CHANNELS];
    logic [PEND_W-1:0] backlog    [CHANNELS];
    logic              slot_full  [CHANNELS][SLOTS];
    logic [SEQ_W-1:0]  slot_seq_no[CHANNELS][SLOTS];
    logic [TAG_W-1:0]  slot_tag_v [CHANNELS][SLOTS];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Reorder prediction for one accepted beat
    task automatic reorder_step(input item_t pkt);
        int               ch;
        int               slot;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] delta;
        logic [SEQ_W-1:0] want;
        result_t          r;
        ch  = (int'(pkt.channel) < CHANNELS) ? int'(pkt.channel) : 0;
        seq = pkt.sequence_req;
        r   = '0;
        if (next_seq[ch] == '0)
            next_seq[ch] = 1;

        // Early, stale or far-off packet: one result
        if (seq != next_seq[ch])
        begin
            delta = seq - next_seq[ch];
            r.released_seq = seq;
            r.last = 1'b1;
            if (delta > HALF_RANGE)
                r.status = ST_STALE;
            else if (delta >= SLOTS)
                r.status = ST_OUT_OF_WINDOW;
            else
            begin
                slot = seq % SLOTS;
                if (slot_full[ch][slot] && slot_seq_no[ch][slot] == seq)
                    r.status = ST_DUPLICATE;
                else
                begin
                    r.status = ST_BUFFERED;
                    if (!slot_full[ch][slot])
                        backlog[ch] = backlog[ch] + 1'b1;
                end
                slot_full[ch][slot]   = 1'b1;
                slot_seq_no[ch][slot] = seq;
                slot_tag_v[ch][slot]  = pkt.payload_tag;
            end
            r.pending_count = backlog[ch];
            outcome_q.push_back(r);
            return;
        end

        // In order: release, then drain the consecutive run
        next_seq[ch] = next_seq[ch] + 1'b1;
        r.status        = ST_DELIVERED;
        r.released_tag  = pkt.payload_tag;
        r.released_seq  = seq;
        r.pending_count = backlog[ch];
        outcome_q.push_back(r);
        want = next_seq[ch];
        slot = want % SLOTS;
        while (slot_full[ch][slot] && slot_seq_no[ch][slot] == want)
        begin
            slot_full[ch][slot] = 1'b0;
            if (backlog[ch] != '0)
                backlog[ch] = backlog[ch] - 1'b1;
            next_seq[ch] = next_seq[ch] + 1'b1;
            r.status        = ST_DRAINED;
            r.released_tag  = slot_tag_v[ch][slot];
            r.released_seq  = want;
            r.pending_count = backlog[ch];
            outcome_q.push_back(r);
            want = next_seq[ch];
            slot = want % SLOTS;
        end
        r = outcome_q.pop_back();
        r.last = 1'b1;
        outcome_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < PRINT_MAX)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    task automatic send(input int ch, input logic [31:0] seq, input logic rel,
                        input logic [15:0] tag);
        item_t pkt;
        pkt.channel      = ch[CHAN_W-1:0];
        pkt.sequence_req = seq;
        pkt.reliable     = rel;
        pkt.payload_tag  = tag;
        packet_q.push_back(pkt);
        queued++;
    endtask

    function automatic logic [31:0] window_base(input int ch);
        return (next_seq[ch] == '0) ? 32'd1 : next_seq[ch];
    endfunction

    // A shuffled run of consecutive sequence numbers from the expected one,
    // sometimes with one repeat mixed in
    task automatic queue_burst(input int ch);
        logic [31:0] base;
        logic [31:0] seqs[$];
        logic [31:0] tmp;
        int          k;
        int          i;
        int          j;
        base = window_base(ch);
        k = ($urandom_range(9) == 0) ? $urandom_range(24, SLOTS) : $urandom_range(1, 6);
        for (i = 0; i < k; i++)
            seqs.push_back(base + i);
        if ($urandom_range(3) == 0)
            seqs.push_back(base + $urandom_range(0, k - 1));
        for (i = seqs.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = seqs[i];
            seqs[i] = seqs[j];
            seqs[j] = tmp;
        end
        for (i = 0; i < seqs.size(); i++)
            send(ch, seqs[i], 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    endtask

    // A lone packet off the expected run
    task automatic queue_stray(input int ch);
        logic [31:0] base;
        logic [31:0] seq;
        base = window_base(ch);
        case ($urandom_range(4))
            0: seq = base + SLOTS + $urandom_range(0, 1000);
            1: seq = base + HALF_RANGE + $urandom_range(0, 1);
            2: seq = base - $urandom_range(1, 64);
            3: seq = $urandom();
            default: seq = base + $urandom_range(1, SLOTS - 1);
        endcase
        send(ch, seq, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)));
    endtask

    // Driver: present a beat, hold it until taken, then maybe idle
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                reorder_step(item);
                accepted++;
            end
            if (!start || taken)
            begin
                if (packet_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    item  <= packet_q.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: check each strobed result and watch for a stall
    always @(posedge clk)
    begin : watch
        result_t want_r;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result with nothing expected, seq",
                                    result.released_seq, 32'd0);
                else
                begin
                    want_r = outcome_q.pop_front();
                    if (result.status !== want_r.status)
                        report_mismatch("status", 32'(result.status),
                                        32'(want_r.status));
                    if (result.released_tag !== want_r.released_tag)
                        report_mismatch("released_tag", 32'(result.released_tag),
                                        32'(want_r.released_tag));
                    if (result.released_seq !== want_r.released_seq)
                        report_mismatch("released_seq", result.released_seq,
                                        want_r.released_seq);
                    if (result.pending_count !== want_r.pending_count)
                        report_mismatch("pending_count", 32'(result.pending_count),
                                        32'(want_r.pending_count));
                    if (result.last !== want_r.last)
                        report_mismatch("last", 32'(result.last), 32'(want_r.last));
                end
            end
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int ph;
        int phase_end;
        for (int c = 0; c < CHANNELS; c++)
        begin
            next_seq[c] = '0;
            backlog[c]  = '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_full[c][s]   = 1'b0;
                slot_seq_no[c][s] = '0;
                slot_tag_v[c][s]  = '0;
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero seen as one, half-way delta, stale, window edge,
        // rewrite of a buffered number, and an in-order drain
        send(0, 32'h0000_0000, 1'b1, 16'h0000);
        send(0, 32'h8000_0001, 1'b0, 16'hFFFF);
        send(0, 32'h8000_0002, 1'b1, 16'h1234);
        send(0, 32'hFFFF_FFFF, 1'b0, 16'h0001);
        send(0, 32'd33,        1'b1, 16'h7FFF);
        send(0, 32'd32,        1'b0, 16'hFFFF);
        send(0, 32'd32,        1'b1, 16'h0000);
        send(0, 32'd3,         1'b0, 16'hA5A5);
        send(0, 32'd2,         1'b1, 16'h5A5A);
        send(0, 32'd1,         1'b0, 16'hFFFF);
        send(1, 32'd1,         1'b1, 16'h8001);
        send(2, 32'd2,         1'b0, 16'h00FF);
        send(2, 32'd1,         1'b1, 16'hFF00);
        send(3, 32'h7FFF_FFFF, 1'b1, 16'h4321);
        send(3, 32'h8000_0000, 1'b0, 16'hC3C3);
        send(3, 32'h8000_0001, 1'b1, 16'h3C3C);
        send(3, 32'd1,         1'b1, 16'hFFFF);

        // Random rounds: sender idles 36%, then 77%, then never
        for (ph = 0; ph < 3; ph++)
        begin
            idle_pct  = (ph == 0) ? 36 : (ph == 1) ? 77 : 0;
            phase_end = queued + PHASE_BEATS;
            while (queued < phase_end)
            begin
                // new round reads predictor state once everything is taken
                while (accepted != queued)
                    @(negedge clk);
                if ($urandom_range(3) == 0)
                    queue_stray($urandom_range(CHANNELS - 1));
                else
                    queue_burst($urandom_range(CHANNELS - 1));
            end
        end

        while (accepted != queued)
            @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (3 + SLOTS + 8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
